// File: design/ptp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_pkg
// Shared constants and register map of the perspective point transform.
// ----------------------------------------------------------------------------
package ptp_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int IO_W            = 32;
    localparam int REG_W           = 64;
    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_W       = 3;
    localparam int CFG_IDX_W       = 8;
    localparam int HALF_W          = 32;

    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    localparam logic [REG_W-1:0] RESET_ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [REG_W-1:0] RESET_ONE_HI = 64'h0001_0000_0000_0000;
    localparam logic [REG_W-1:0] RESET_ZERO   = 64'h0;

endpackage

// File: design/ptp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_if
// Handshake channels: input point, result and register write.
// ----------------------------------------------------------------------------
interface ptp_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptp_pkg::IO_W-1:0]     point_x;
    logic signed [ptp_pkg::IO_W-1:0]     point_y;
    logic signed [ptp_pkg::IO_W-1:0]     point_z;
    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

interface ptp_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [ptp_pkg::IO_W-1:0]     result_x;
    logic signed [ptp_pkg::IO_W-1:0]     result_y;
    logic signed [ptp_pkg::IO_W-1:0]     result_z;
    logic                                w_was_zero;
    logic                                overflowed;
    modport source (output valid, output result_x, output result_y, output result_z,
                    output w_was_zero, output overflowed, input ready);
    modport sink   (input valid, input result_x, input result_y, input result_z,
                    input w_was_zero, input overflowed, output ready);
endinterface

interface ptp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [ptp_pkg::CFG_IDX_W-1:0]       index;
    logic [ptp_pkg::REG_W-1:0]           data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/ptp_dot.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_dot
// One column lane: three products, then floored sum plus translation entry.
// ----------------------------------------------------------------------------
module ptp_dot #(
    parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ptp_pkg::FRAC_BITS_DEF,
    parameter int SUM_W       = 2 * COORD_WIDTH + 3 - FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_en_mul,
    input  logic                          i_en_sum,
    input  logic signed [COORD_WIDTH-1:0] i_p [3],
    input  logic signed [COORD_WIDTH-1:0] i_m [4],
    output logic signed [SUM_W-1:0]       o_sum
);
    localparam int PW  = 2 * COORD_WIDTH;
    localparam int ACW = PW + 2;
    localparam int FLW = ACW - FRAC_BITS;

    logic signed [PW-1:0]    r_prod [3];
    logic signed [ACW-1:0]   w_acc;
    logic signed [FLW-1:0]   w_fl;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [SUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= PW'(i_p[i]) * PW'(i_m[i]);
            end
        end
        if (i_en_sum) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        w_acc = ACW'(r_prod[0]) + ACW'(r_prod[1]) + ACW'(r_prod[2]);
        w_fl  = $signed(w_acc[ACW-1:FRAC_BITS]);
        n_sum = SUM_W'(w_fl) + SUM_W'(i_m[3]);
    end

    assign o_sum = r_sum;
endmodule

// File: design/ptp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_div
// Pipelined restoring divider: trunc(num * 2^F / den), one quotient bit a stage.
// ----------------------------------------------------------------------------
module ptp_div #(
    parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ptp_pkg::FRAC_BITS_DEF,
    parameter int SUM_W       = 2 * COORD_WIDTH + 3 - FRAC_BITS
) (
    input  logic                    i_clk,
    input  logic [COORD_WIDTH+1:0]  i_en,
    input  logic signed [SUM_W-1:0] i_num,
    input  logic signed [SUM_W-1:0] i_den,
    output logic [COORD_WIDTH-1:0]  o_q,
    output logic                    o_neg,
    output logic                    o_over,
    output logic                    o_wz
);
    localparam int AW = SUM_W + COORD_WIDTH + FRAC_BITS;

    logic [SUM_W-1:0]       w_an;
    logic [SUM_W-1:0]       w_ad;
    logic [AW-1:0]          r_n0;
    logic [SUM_W-1:0]       r_d0;
    logic                   r_ng0;
    logic                   r_wz0;

    logic [AW-1:0]          r_r  [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0] r_q  [COORD_WIDTH+1];
    logic [SUM_W-1:0]       r_d  [COORD_WIDTH+1];
    logic                   r_ng [COORD_WIDTH+1];
    logic                   r_wz [COORD_WIDTH+1];
    logic                   r_ov [COORD_WIDTH+1];

    assign w_an = i_num[SUM_W-1] ? SUM_W'(-i_num) : i_num;
    assign w_ad = i_den[SUM_W-1] ? SUM_W'(-i_den) : i_den;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_n0  <= AW'(w_an) << FRAC_BITS;
            r_d0  <= w_ad;
            r_ng0 <= i_num[SUM_W-1] ^ i_den[SUM_W-1];
            r_wz0 <= (i_den == '0);
        end
        if (i_en[1]) begin
            r_r[0]  <= r_n0;
            r_q[0]  <= '0;
            r_d[0]  <= r_d0;
            r_ng[0] <= r_ng0;
            r_wz[0] <= r_wz0;
            r_ov[0] <= (r_n0 >= (AW'(r_d0) << COORD_WIDTH));
        end
    end

    for (genvar j = 0; j < COORD_WIDTH; j++) begin : g_step
        localparam int K = COORD_WIDTH - 1 - j;
        logic [AW-1:0] w_sub;
        assign w_sub = AW'(r_d[j]) << K;
        always_ff @(posedge i_clk) begin
            if (i_en[j+2]) begin
                if (r_r[j] >= w_sub) begin
                    r_r[j+1] <= r_r[j] - w_sub;
                    r_q[j+1] <= r_q[j] | (COORD_WIDTH'(1) << K);
                end else begin
                    r_r[j+1] <= r_r[j];
                    r_q[j+1] <= r_q[j];
                end
                r_d[j+1]  <= r_d[j];
                r_ng[j+1] <= r_ng[j];
                r_wz[j+1] <= r_wz[j];
                r_ov[j+1] <= r_ov[j];
            end
        end
    end

    assign o_q    = r_q[COORD_WIDTH];
    assign o_neg  = r_ng[COORD_WIDTH];
    assign o_over = r_ov[COORD_WIDTH];
    assign o_wz   = r_wz[COORD_WIDTH];
endmodule

// File: design/ptp_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptp_merge
// Saturate and sign the three quotients, merge flags into the output register.
// ----------------------------------------------------------------------------
module ptp_merge #(
    parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [COORD_WIDTH-1:0]            i_q    [3],
    input  logic                              i_neg  [3],
    input  logic                              i_over [3],
    input  logic                              i_wz,
    output logic signed [ptp_pkg::IO_W-1:0]   o_res  [3],
    output logic                              o_wz,
    output logic                              o_ovf
);
    localparam logic [COORD_WIDTH-1:0] LIM_POS = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] LIM_NEG = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [COORD_WIDTH-1:0]            w_lim [3];
    logic [COORD_WIDTH-1:0]            w_val [3];
    logic                              w_sat [3];
    logic signed [ptp_pkg::IO_W-1:0]   n_res [3];
    logic                              n_ovf;
    logic signed [ptp_pkg::IO_W-1:0]   r_res [3];
    logic                              r_wz;
    logic                              r_ovf;

    always_comb begin
        n_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_lim[i] = i_neg[i] ? LIM_NEG : LIM_POS;
            w_sat[i] = i_over[i] || (i_q[i] > w_lim[i]);
            w_val[i] = w_sat[i] ? w_lim[i] : i_q[i];
            w_val[i] = i_neg[i] ? (~w_val[i] + COORD_WIDTH'(1)) : w_val[i];
            n_res[i] = i_wz ? '0 : ptp_pkg::IO_W'($signed(w_val[i]));
            n_ovf    = n_ovf | w_sat[i];
        end
        if (i_wz) begin
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_wz  <= i_wz;
            r_ovf <= n_ovf;
        end
    end

    assign o_res = r_res;
    assign o_wz  = r_wz;
    assign o_ovf = r_ovf;
endmodule

// File: design/point_transform_perspective.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_transform_perspective
// Row vector (x,y,z,1) times a 4x4 Q matrix, then X, Y, Z divided by W.
// ----------------------------------------------------------------------------
// One point is taken per clock unless a stalled output holds the pipeline,
// and results leave in order, one per point. Four column lanes form X, Y, Z
// and W in two stages; three divider lanes then resolve one quotient bit
// per stage, which sets the latency. Any stage whose successor is empty or
// moving advances, so bubbles close up under a stalled output. Registers
// must be written by the user through the configuration channel only while
// no point is in flight, not enforced here; reset loads the identity matrix.
module point_transform_perspective #(
    parameter int COORD_WIDTH = ptp_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = ptp_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ptp_point_if.sink     i_point,
    ptp_cfg_if.sink       i_cfg,
    ptp_result_if.source  o_result
);
    localparam int SUM_W = 2 * COORD_WIDTH + 3 - FRAC_BITS;
    localparam int NS    = COORD_WIDTH + 5;

    logic [ptp_pkg::REG_W-1:0]  r_cfg [ptp_pkg::NUM_REGS];
    logic [NS-1:0]              r_v;
    logic [NS-1:0]              w_en;

    logic signed [COORD_WIDTH-1:0] w_p   [3];
    logic signed [COORD_WIDTH-1:0] w_m   [4][4];
    logic signed [SUM_W-1:0]       w_col [4];
    logic [COORD_WIDTH-1:0]        w_q   [3];
    logic                          w_neg [3];
    logic                          w_ovr [3];
    logic                          w_wz  [3];
    logic signed [ptp_pkg::IO_W-1:0] w_res [3];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[ptp_pkg::REG_ROW0_COLS01] <= ptp_pkg::RESET_ONE_LO;
            r_cfg[ptp_pkg::REG_ROW0_COLS23] <= ptp_pkg::RESET_ZERO;
            r_cfg[ptp_pkg::REG_ROW1_COLS01] <= ptp_pkg::RESET_ONE_HI;
            r_cfg[ptp_pkg::REG_ROW1_COLS23] <= ptp_pkg::RESET_ZERO;
            r_cfg[ptp_pkg::REG_ROW2_COLS01] <= ptp_pkg::RESET_ZERO;
            r_cfg[ptp_pkg::REG_ROW2_COLS23] <= ptp_pkg::RESET_ONE_LO;
            r_cfg[ptp_pkg::REG_ROW3_COLS01] <= ptp_pkg::RESET_ZERO;
            r_cfg[ptp_pkg::REG_ROW3_COLS23] <= ptp_pkg::RESET_ONE_HI;
        end else if (i_cfg.valid &&
                     i_cfg.index < ptp_pkg::CFG_IDX_W'(ptp_pkg::NUM_REGS)) begin
            r_cfg[i_cfg.index[ptp_pkg::REG_IDX_W-1:0]] <= i_cfg.data;
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_row
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign w_m[r][c] = $signed(
                r_cfg[r*2 + c/2][(c%2)*ptp_pkg::HALF_W +: COORD_WIDTH]);
        end
    end

    assign w_p[0] = $signed(i_point.point_x[COORD_WIDTH-1:0]);
    assign w_p[1] = $signed(i_point.point_y[COORD_WIDTH-1:0]);
    assign w_p[2] = $signed(i_point.point_z[COORD_WIDTH-1:0]);

    assign w_en[NS-1] = ~r_v[NS-1] | o_result.ready;
    for (genvar s = 0; s < NS-1; s++) begin : g_en
        assign w_en[s] = ~r_v[s] | w_en[s+1];
    end

    assign i_point.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_point.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
        logic signed [COORD_WIDTH-1:0] w_mc [4];
        for (genvar r = 0; r < 4; r++) begin : g_m
            assign w_mc[r] = w_m[r][c];
        end
        ptp_dot #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .SUM_W       (SUM_W)
        ) u_dot (
            .i_clk    (i_clk),
            .i_en_mul (w_en[0]),
            .i_en_sum (w_en[1]),
            .i_p      (w_p),
            .i_m      (w_mc),
            .o_sum    (w_col[c])
        );
    end

    for (genvar c = 0; c < 3; c++) begin : g_div
        ptp_div #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .SUM_W       (SUM_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en[COORD_WIDTH+3:2]),
            .i_num  (w_col[c]),
            .i_den  (w_col[3]),
            .o_q    (w_q[c]),
            .o_neg  (w_neg[c]),
            .o_over (w_ovr[c]),
            .o_wz   (w_wz[c])
        );
    end

    ptp_merge #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en[NS-1]),
        .i_q    (w_q),
        .i_neg  (w_neg),
        .i_over (w_ovr),
        .i_wz   (w_wz[0]),
        .o_res  (w_res),
        .o_wz   (o_result.w_was_zero),
        .o_ovf  (o_result.overflowed)
    );

    assign o_result.valid    = r_v[NS-1];
    assign o_result.result_x = w_res[0];
    assign o_result.result_y = w_res[1];
    assign o_result.result_z = w_res[2];

    a_zero_w_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.w_was_zero |-> !o_result.overflowed)
        else $error("overflow flagged on a zero W beat");

    a_zero_w_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.w_was_zero |->
        (o_result.result_x == '0) && (o_result.result_y == '0) &&
        (o_result.result_z == '0))
        else $error("non-zero result on a zero W beat");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_result.valid |-> i_point.ready)
        else $error("input stalled with an empty output stage");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result beat straight after reset");
endmodule
